### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, quiet while in reset.
`define IAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge, quiet while in reset.
`define IAT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hdl/iat_pkg.sv
// ----------------------------------------------------------------------------
// iat_pkg
// Types, codes and lookup functions of the indent-aware tokenizer.
// ----------------------------------------------------------------------------
package iat_pkg;

  localparam int unsigned INDENT_DEPTH_DEF = 16;
  localparam int unsigned POS_BITS_DEF     = 16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [1:0] WS_NONE  = 2'd0;
  localparam logic [1:0] WS_SPACE = 2'd1;
  localparam logic [1:0] WS_TAB   = 2'd2;

  typedef enum logic [5:0] {
    K_EOF, K_ID, K_STRING, K_NUMBER, K_COLON, K_DOT, K_COMMA, K_LPR, K_RPR,
    K_LSBR, K_RSBR, K_LBR, K_RBR, K_PLUS, K_PLUSASS, K_MINUS, K_MINASS, K_ARROW,
    K_STAR, K_MULASS, K_DIV, K_DIVASS, K_IDIV, K_IDIVASS, K_MOD, K_MODASS,
    K_MATMUL, K_MATMULASS, K_GREATER, K_GREQUAL, K_RSHIFT, K_RSHIFTASS,
    K_LESS, K_LEQUAL, K_LSHIFT, K_LSHIFTASS, K_ASSIGN, K_EQUAL, K_INV,
    K_BAND, K_BANDASS, K_BOR, K_BORASS, K_XOR, K_XORASS, K_NOTEQ,
    K_UNEXPECTED, K_NEWLINE, K_INDENT, K_DEDENT, K_INDENTERROR,
    K_TABSPACEMIX, K_TEXT
  } kind_e;

  typedef enum logic [5:0] {
    M_START, M_SKIP, M_ID, M_STRING, M_NUM1, M_NUM2, M_COMMENT, M_NEWLINE,
    M_INDENT,
    M_PLUS, M_MINUS, M_STAR, M_DIV, M_MOD, M_MATMUL, M_GREATER, M_LESS,
    M_ASSIGN, M_INV, M_BAND, M_BOR, M_XOR, M_EXCL, M_IDIV, M_LSHIFT,
    M_RSHIFT, M_COLON, M_DOT, M_COMMA, M_LPR, M_RPR, M_LSBR, M_RSBR, M_LBR,
    M_RBR
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_DED, S_DWAIT, S_ERR, S_TAIL, S_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    SEL_PRE, SEL_DED, SEL_ERR, SEL_TAIL
  } sel_e;

  typedef struct packed {
    logic  accept;
    logic  emit;
    sel_e  sel;
    logic  pop;
    logic  load_top;
    logic  reseed;
    logic  flush;
  } cmd_t;

  typedef struct packed {
    logic pre_v;
    logic ded_v;
    logic tail_v;
    logic ded_more;
    logic lp_zero;
    logic lp_one;
    logic stage_free;
    logic stage_v;
    logic adv;
  } sts_t;

  typedef struct packed {
    logic  is_op;
    kind_e base;
    logic  eq_v;
    kind_e eq;
    logic  ch2_v;
    logic [7:0] ch2;
    logic  act2_mode;
    kind_e act2_kind;
    mode_e act2_m;
  } op_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic id_begin(input logic [7:0] c);
    return is_alpha(c) || c == CH_UNDER;
  endfunction

  function automatic logic id_char(input logic [7:0] c);
    return id_begin(c) || is_digit(c);
  endfunction

  function automatic op_t mk_op(input kind_e b, input logic ev, input kind_e e);
    op_t o;
    o = '{is_op: 1'b1, base: b, eq_v: ev, eq: e, ch2_v: 1'b0, ch2: CH_NUL,
          act2_mode: 1'b0, act2_kind: K_EOF, act2_m: M_START};
    return o;
  endfunction

  function automatic op_t op_lookup(input mode_e m);
    op_t o;
    o = mk_op(K_EOF, 1'b0, K_EOF);
    o.is_op = 1'b0;
    case (m)
      M_PLUS:    o = mk_op(K_PLUS, 1'b1, K_PLUSASS);
      M_MINUS: begin
        o = mk_op(K_MINUS, 1'b1, K_MINASS);
        o.ch2_v = 1'b1; o.ch2 = ">"; o.act2_kind = K_ARROW;
      end
      M_STAR:    o = mk_op(K_STAR, 1'b1, K_MULASS);
      M_DIV: begin
        o = mk_op(K_DIV, 1'b1, K_DIVASS);
        o.ch2_v = 1'b1; o.ch2 = "/"; o.act2_mode = 1'b1; o.act2_m = M_IDIV;
      end
      M_MOD:     o = mk_op(K_MOD, 1'b1, K_MODASS);
      M_MATMUL:  o = mk_op(K_MATMUL, 1'b1, K_MATMULASS);
      M_GREATER: begin
        o = mk_op(K_GREATER, 1'b1, K_GREQUAL);
        o.ch2_v = 1'b1; o.ch2 = ">"; o.act2_mode = 1'b1; o.act2_m = M_RSHIFT;
      end
      M_LESS: begin
        o = mk_op(K_LESS, 1'b1, K_LEQUAL);
        o.ch2_v = 1'b1; o.ch2 = "<"; o.act2_mode = 1'b1; o.act2_m = M_LSHIFT;
      end
      M_ASSIGN:  o = mk_op(K_ASSIGN, 1'b1, K_EQUAL);
      M_INV:     o = mk_op(K_INV, 1'b0, K_EOF);
      M_BAND:    o = mk_op(K_BAND, 1'b1, K_BANDASS);
      M_BOR:     o = mk_op(K_BOR, 1'b1, K_BORASS);
      M_XOR:     o = mk_op(K_XOR, 1'b1, K_XORASS);
      M_EXCL:    o = mk_op(K_UNEXPECTED, 1'b1, K_NOTEQ);
      M_IDIV:    o = mk_op(K_IDIV, 1'b1, K_IDIVASS);
      M_LSHIFT:  o = mk_op(K_LSHIFT, 1'b1, K_LSHIFTASS);
      M_RSHIFT:  o = mk_op(K_RSHIFT, 1'b1, K_RSHIFTASS);
      M_COLON:   o = mk_op(K_COLON, 1'b0, K_EOF);
      M_DOT:     o = mk_op(K_DOT, 1'b0, K_EOF);
      M_COMMA:   o = mk_op(K_COMMA, 1'b0, K_EOF);
      M_LPR:     o = mk_op(K_LPR, 1'b0, K_EOF);
      M_RPR:     o = mk_op(K_RPR, 1'b0, K_EOF);
      M_LSBR:    o = mk_op(K_LSBR, 1'b0, K_EOF);
      M_RSBR:    o = mk_op(K_RSBR, 1'b0, K_EOF);
      M_LBR:     o = mk_op(K_LBR, 1'b0, K_EOF);
      M_RBR:     o = mk_op(K_RBR, 1'b0, K_EOF);
      default:   o.is_op = 1'b0;
    endcase
    return o;
  endfunction

  // Mode entered for a byte that opens an operator, string or skip.
  function automatic mode_e dispatch_mode(input logic [7:0] c);
    mode_e m;
    case (c)
      "+":      m = M_PLUS;
      "-":      m = M_MINUS;
      "*":      m = M_STAR;
      "/":      m = M_DIV;
      "@":      m = M_MATMUL;
      "%":      m = M_MOD;
      "&":      m = M_BAND;
      "|":      m = M_BOR;
      "^":      m = M_XOR;
      "!":      m = M_EXCL;
      "<":      m = M_LESS;
      ">":      m = M_GREATER;
      "=":      m = M_ASSIGN;
      "~":      m = M_INV;
      ".":      m = M_DOT;
      ",":      m = M_COMMA;
      "(":      m = M_LPR;
      ")":      m = M_RPR;
      "[":      m = M_LSBR;
      "]":      m = M_RSBR;
      "{":      m = M_LBR;
      "}":      m = M_RBR;
      ":":      m = M_COLON;
      CH_QUOTE: m = M_STRING;
      default:  m = M_SKIP;
    endcase
    return m;
  endfunction

endpackage

### hdl/iat_ctrl.sv
// ----------------------------------------------------------------------------
// iat_ctrl
// Sequencer: walks one byte's result slots (pre, dedents, error, tail, flush).
// ----------------------------------------------------------------------------
module iat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  iat_pkg::sts_t sts_i,
  output iat_pkg::cmd_t cmd_o
);
  import iat_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '{accept: 1'b0, emit: 1'b0, sel: SEL_PRE, pop: 1'b0,
                   load_top: 1'b0, reseed: 1'b0, flush: 1'b0};
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PRE;
        end
      end
      S_PRE: begin
        if (!sts_i.pre_v) begin
          state_d = S_DED;
        end else if (sts_i.stage_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_PRE;
          state_d    = S_DED;
        end
      end
      S_DED: begin
        if (!sts_i.ded_v) begin
          state_d = S_TAIL;
        end else if (sts_i.ded_more) begin
          if (sts_i.stage_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.sel  = SEL_DED;
            cmd_o.pop  = 1'b1;
            state_d    = sts_i.lp_one ? S_DED : S_DWAIT;
          end
        end else begin
          state_d = sts_i.lp_zero ? S_ERR : S_TAIL;
        end
      end
      S_DWAIT: begin
        cmd_o.load_top = 1'b1;
        state_d        = S_DED;
      end
      S_ERR: begin
        if (sts_i.stage_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.sel    = SEL_ERR;
          cmd_o.reseed = 1'b1;
          state_d      = S_TAIL;
        end
      end
      S_TAIL: begin
        if (!sts_i.tail_v) begin
          state_d = S_FLUSH;
        end else if (sts_i.stage_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_TAIL;
          state_d    = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts_i.stage_v) begin
          state_d = S_IDLE;
        end else if (sts_i.adv) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### hdl/iat_dp.sv
// ----------------------------------------------------------------------------
// iat_dp
// Datapath: lexer state, indent stack, result staging and output register.
// ----------------------------------------------------------------------------
module iat_dp #(
  parameter int unsigned INDENT_DEPTH = iat_pkg::INDENT_DEPTH_DEF,
  parameter int unsigned POS_BITS     = iat_pkg::POS_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    char_code_i,
  input  iat_pkg::cmd_t cmd_i,
  output iat_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [5:0]    kind_o,
  output logic [15:0]   row_o,
  output logic [15:0]   column_o,
  output logic [7:0]    text_byte_o,
  output logic          last_o
);
  import iat_pkg::*;

  localparam int unsigned LPW = $clog2(INDENT_DEPTH + 1);
  localparam int unsigned AW  = $clog2(INDENT_DEPTH);

  // lexer state
  mode_e               mode_q;
  logic [POS_BITS-1:0] row_q, col_q, ts_q;
  logic [7:0]          icnt_q;
  logic [1:0]          pw_q, style_q;
  logic [LPW-1:0]      lp_q;
  logic [7:0]          top_q, rd_q;
  logic [7:0]          mem_q [INDENT_DEPTH];

  // per-byte plan
  logic        pre_v_q, ded_v_q, tail_v_q;
  kind_e       pre_k_q, tail_k_q;
  logic [7:0]  tgt_q, tail_b_q;
  logic [15:0] res_row_q, put_col_q, tail_col_q;

  // staging and output
  logic        st_v_q, ov_q, last_q;
  kind_e       st_k_q, ok_q;
  logic [15:0] st_row_q, st_col_q, orow_q, ocol_q;
  logic [7:0]  st_b_q, ob_q;

  function automatic logic [15:0] clamp16(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  // next-state evaluation of one byte
  op_t                 op;
  logic [7:0]          c;
  logic [POS_BITS-1:0] col_inc, row_inc, row_n, col_n, ts_n;
  mode_e               mode_n;
  logic [7:0]          ic_n, ic1;
  logic [1:0]          pw_n, style_n, s1, s2, w;
  logic                pre_v, ded_v, push, t_v, t_cur, do_tail, do_disp;
  kind_e               pre_k, t_k;
  logic [7:0]          tgt, t_b;

  always_comb begin
    c       = char_code_i;
    op      = op_lookup(mode_q);
    col_inc = (col_q == '1) ? col_q : col_q + 1'b1;
    row_inc = (row_q == '1) ? row_q : row_q + 1'b1;
    mode_n  = mode_q;
    row_n   = row_q;
    col_n   = col_q;
    ts_n    = ts_q;
    ic_n    = icnt_q;
    ic1     = icnt_q;
    pw_n    = pw_q;
    style_n = style_q;
    s1      = style_q;
    s2      = style_q;
    w       = WS_SPACE;
    pre_v   = 1'b0;
    pre_k   = K_EOF;
    ded_v   = 1'b0;
    tgt     = 8'd0;
    push    = 1'b0;
    t_v     = 1'b0;
    t_k     = K_TEXT;
    t_cur   = 1'b1;
    t_b     = 8'd0;
    do_tail = 1'b0;
    do_disp = 1'b0;
    case (mode_q)
      M_START: begin
        if (c == CH_HASH) begin
          mode_n = M_COMMENT; ts_n = col_n;
        end else if (c == CH_SPACE || c == CH_TAB) begin
          mode_n = M_INDENT; ts_n = col_n; ic_n = 8'd0; pw_n = WS_NONE;
        end else if (c != CH_NL) begin
          do_tail = 1'b1;
        end
      end
      M_SKIP: begin
        col_n = col_inc; do_tail = 1'b1;
      end
      M_ID: begin
        col_n = col_inc;
        if (id_char(c)) begin
          t_v = 1'b1; t_b = c;
        end else begin
          pre_v = 1'b1; pre_k = K_ID; do_disp = 1'b1;
        end
      end
      M_STRING: begin
        col_n = col_inc;
        if (c == CH_QUOTE) begin
          pre_v = 1'b1; pre_k = K_STRING; mode_n = M_SKIP; ts_n = col_n;
        end else begin
          t_v = 1'b1; t_b = c;
        end
      end
      M_NUM1: begin
        col_n = col_inc;
        if (is_digit(c)) begin
          t_v = 1'b1; t_b = c;
        end else if (c == CH_DOT) begin
          t_v = 1'b1; t_b = c; mode_n = M_NUM2;
        end else begin
          pre_v = 1'b1; pre_k = K_NUMBER; do_tail = 1'b1;
        end
      end
      M_NUM2: begin
        col_n = col_inc;
        if (is_digit(c)) begin
          t_v = 1'b1; t_b = c;
        end else begin
          pre_v = 1'b1; pre_k = K_NUMBER; do_disp = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == CH_NL) begin
          row_n = row_inc; col_n = '0;
          mode_n = M_INDENT; ts_n = '0; ic_n = 8'd0; pw_n = WS_NONE;
        end
      end
      M_NEWLINE: begin
        col_n = POS_BITS'(1);
        row_n = row_inc;
        if (c == CH_NL) begin
          mode_n = mode_q;
        end else if (c == CH_HASH) begin
          mode_n = M_COMMENT; ts_n = col_n;
        end else if (c == CH_NUL) begin
          pre_v = 1'b1; pre_k = K_EOF;
        end else if (c == CH_SPACE || c == CH_TAB) begin
          mode_n = M_INDENT; ts_n = col_n; ic_n = 8'd0;
          pw_n = (c == CH_SPACE) ? WS_SPACE : WS_TAB;
        end else begin
          ded_v = 1'b1; tgt = 8'd0; do_tail = 1'b1;
        end
      end
      M_INDENT: begin
        col_n = col_inc;
        if (c == CH_NL) begin
          pw_n = WS_NONE; ic_n = 8'd0; row_n = row_inc; col_n = '0;
        end else if (c == CH_HASH) begin
          mode_n = M_COMMENT; ts_n = col_n;
        end else begin
          if (pw_q != WS_NONE) begin
            s1 = (style_q == WS_NONE) ? pw_q : style_q;
          end
          style_n = s1;
          if (pw_q != WS_NONE && pw_q != s1) begin
            // mismatched pending blank: line stays in mix state
            pre_v = 1'b1; pre_k = K_TABSPACEMIX;
          end else begin
            if (pw_q != WS_NONE) begin
              ic1  = (icnt_q == 8'hFF) ? icnt_q : icnt_q + 8'd1;
              pw_n = WS_NONE;
            end
            ic_n = ic1;
            if (c == CH_SPACE || c == CH_TAB) begin
              w       = (c == CH_SPACE) ? WS_SPACE : WS_TAB;
              s2      = (s1 == WS_NONE) ? w : s1;
              style_n = s2;
              if (w == s2) begin
                ic_n = (ic1 == 8'hFF) ? ic1 : ic1 + 8'd1;
              end else begin
                pre_v = 1'b1; pre_k = K_TABSPACEMIX;
              end
            end else begin
              if (ic1 > top_q) begin
                push = 1'b1; pre_v = 1'b1; pre_k = K_INDENT;
              end else if (ic1 < top_q) begin
                ded_v = 1'b1; tgt = ic1;
              end
              do_tail = 1'b1;
            end
          end
        end
      end
      default: begin
        if (op.is_op) begin
          col_n = col_inc;
          if (op.eq_v && c == CH_EQ) begin
            pre_v = 1'b1; pre_k = op.eq; mode_n = M_SKIP; ts_n = col_n;
          end else if (op.ch2_v && c == op.ch2) begin
            if (op.act2_mode) begin
              mode_n = op.act2_m; ts_n = col_n;
            end else begin
              pre_v = 1'b1; pre_k = op.act2_kind; mode_n = M_SKIP; ts_n = col_n;
            end
          end else begin
            pre_v = 1'b1; pre_k = op.base; do_tail = 1'b1;
          end
        end else begin
          mode_n = M_START;
        end
      end
    endcase

    if (do_tail && id_begin(c)) begin
      t_v = 1'b1; t_b = c; mode_n = M_ID; ts_n = col_n;
    end else if (do_tail && is_digit(c)) begin
      t_v = 1'b1; t_b = c; mode_n = M_NUM1; ts_n = col_n;
    end else if (do_tail || do_disp) begin
      if (c == CH_HASH) begin
        t_v = 1'b1; t_k = K_NEWLINE; mode_n = M_COMMENT; ts_n = col_n;
      end else if (c == CH_NL) begin
        t_v = 1'b1; t_k = K_NEWLINE; mode_n = M_NEWLINE; ts_n = col_n;
      end else if (c == CH_NUL) begin
        t_v = 1'b1; t_k = K_EOF; t_cur = 1'b0;
      end else begin
        mode_n = dispatch_mode(c); ts_n = col_n;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_START;
      row_q    <= '0;
      col_q    <= '0;
      ts_q     <= '0;
      icnt_q   <= 8'd0;
      pw_q     <= WS_NONE;
      style_q  <= WS_NONE;
      lp_q     <= LPW'(1);
      top_q    <= 8'd0;
      pre_v_q  <= 1'b0;
      ded_v_q  <= 1'b0;
      tail_v_q <= 1'b0;
      st_v_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        mode_q   <= mode_n;
        row_q    <= row_n;
        col_q    <= col_n;
        ts_q     <= ts_n;
        icnt_q   <= ic_n;
        pw_q     <= pw_n;
        style_q  <= style_n;
        pre_v_q  <= pre_v;
        ded_v_q  <= ded_v;
        tail_v_q <= t_v;
        if (push) begin
          top_q <= ic1;
          if (lp_q < LPW'(INDENT_DEPTH)) begin
            lp_q <= lp_q + LPW'(1);
          end
        end
      end
      if (cmd_i.pop) begin
        lp_q <= lp_q - LPW'(1);
      end
      if (cmd_i.load_top) begin
        top_q <= rd_q;
      end
      if (cmd_i.reseed) begin
        lp_q  <= LPW'(1);
        top_q <= 8'd0;
      end
      if (cmd_i.emit) begin
        st_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        st_v_q <= 1'b0;
      end
      if ((cmd_i.emit || cmd_i.flush) && st_v_q) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // indent stack; entry zero only ever holds level zero
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [LPW-1:0] lp_m2;

  assign wr_addr = (lp_q < LPW'(INDENT_DEPTH)) ? lp_q[AW-1:0] : AW'(INDENT_DEPTH - 1);
  assign lp_m2   = lp_q - LPW'(2);
  assign rd_addr = lp_m2[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && push) begin
      mem_q[wr_addr] <= ic1;
    end
    rd_q <= (rd_addr == '0) ? 8'd0 : mem_q[rd_addr];
  end

  // plan and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pre_k_q    <= pre_k;
      tgt_q      <= tgt;
      tail_k_q   <= t_k;
      tail_b_q   <= t_b;
      res_row_q  <= clamp16(row_n);
      put_col_q  <= clamp16(ts_q);
      tail_col_q <= t_cur ? clamp16(col_n) : clamp16(ts_q);
    end
    if (cmd_i.emit) begin
      st_row_q <= res_row_q;
      case (cmd_i.sel)
        SEL_PRE:  begin st_k_q <= pre_k_q;       st_col_q <= put_col_q;  st_b_q <= 8'd0; end
        SEL_DED:  begin st_k_q <= K_DEDENT;      st_col_q <= put_col_q;  st_b_q <= 8'd0; end
        SEL_ERR:  begin st_k_q <= K_INDENTERROR; st_col_q <= put_col_q;  st_b_q <= 8'd0; end
        SEL_TAIL: begin st_k_q <= tail_k_q;      st_col_q <= tail_col_q; st_b_q <= tail_b_q; end
        default:  begin st_k_q <= pre_k_q;       st_col_q <= put_col_q;  st_b_q <= 8'd0; end
      endcase
    end
    if ((cmd_i.emit || cmd_i.flush) && st_v_q) begin
      ok_q   <= st_k_q;
      orow_q <= st_row_q;
      ocol_q <= st_col_q;
      ob_q   <= st_b_q;
      last_q <= cmd_i.flush;
    end
  end

  always_comb begin
    sts_o.pre_v      = pre_v_q;
    sts_o.ded_v      = ded_v_q;
    sts_o.tail_v     = tail_v_q;
    sts_o.ded_more   = (lp_q != '0) && (top_q != tgt_q);
    sts_o.lp_zero    = (lp_q == '0);
    sts_o.lp_one     = (lp_q == LPW'(1));
    sts_o.adv        = !ov_q || out_ready_i;
    sts_o.stage_free = !st_v_q || sts_o.adv;
    sts_o.stage_v    = st_v_q;
  end

  assign out_valid_o = ov_q;
  assign kind_o      = ok_q;
  assign row_o       = orow_q;
  assign column_o    = ocol_q;
  assign text_byte_o = ob_q;
  assign last_o      = last_q;

endmodule

### hdl/indent_aware_tokenizer.sv
// ----------------------------------------------------------------------------
// indent_aware_tokenizer
// Line-oriented lexer with an indent stack, one source byte per input beat.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o carry one source byte in char_code_i;
// a zero byte outside a string or comment ends input with an eof record.
// Output channel: out_valid_o / out_ready_i carry result beats (kind, row,
// column, text_byte); last_o flags the final beat caused by an input byte.
// A byte may cause no beat at all (whitespace, comment bytes).
// Sequence: an accepted byte is worked through in its own slots: plan, optional
// leading record, the dedent loop, optional indent error, optional tail record,
// then a flush of the staged beat. The dedent loop passes through a wait state
// after every pop but the one that empties the stack, because the stack memory
// has a registered read port. Results pass through a staging register and an
// output register, so the next byte is accepted while the last beat still
// waits on out_ready_i.
// Receiver stall: the sequencer holds in its current slot until the output
// register frees up; nothing is dropped.
// Reset (rst_ni low, async): start mode, row/column zero, stack holding the
// single level zero, no beats pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module indent_aware_tokenizer #(
  parameter int unsigned INDENT_DEPTH = iat_pkg::INDENT_DEPTH_DEF,
  parameter int unsigned POS_BITS     = iat_pkg::POS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  kind_o,
  output logic [15:0] row_o,
  output logic [15:0] column_o,
  output logic [7:0]  text_byte_o,
  output logic        last_o
);
  import iat_pkg::*;

  `include "assert_macros.svh"

  cmd_t cmd;  // sequencer -> datapath
  sts_t sts;  // datapath -> sequencer

  iat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iat_dp #(
    .INDENT_DEPTH (INDENT_DEPTH),
    .POS_BITS     (POS_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (char_code_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .row_o       (row_o),
    .column_o    (column_o),
    .text_byte_o (text_byte_o),
    .last_o      (last_o)
  );

  // one byte in flight: busy right after an accept
  `IAT_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "accepted while busy")
  // never pop an empty stack
  `IAT_NEVER(a_pop_nonempty, cmd.pop && sts.lp_zero, "pop on empty indent stack")
  // staging only loads when its beat can move on
  `IAT_ASSERT(a_emit_room, cmd.emit |-> sts.stage_free, "staging overrun")

endmodule

### dv/indent_aware_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// indent_aware_tokenizer_tb
// Self-checking bench for the indent-aware tokenizer. A byte-level lexer
// model predicts every result beat (text bytes, token records, indent and
// dedent records). A monitor compares the beats the block returns against
// those predictions, in order. The source text is directed lines followed by
// random program-like lines, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module indent_aware_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iat_pkg::*;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned MAX_BEATS   = 19;
  localparam int unsigned POS_LIMIT   = 65535;
  localparam int unsigned DRAIN_QUIET = 48;     // covers a byte's full run, dedents included
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    kind_e       kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [7:0]  text;
    logic        last;
  } token_beat_t;

  typedef struct {
    logic [7:0] code;
    int         phase;  // idle profile in force while this byte is sent
    logic       drain;  // wait for every pending beat before sending
    logic       hold;   // start a long receiver hold-off once sent
  } src_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  kind_o;
  logic [15:0] row_o;
  logic [15:0] column_o;
  logic [7:0]  text_byte_o;
  logic        last_o;

  indent_aware_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .row_o       (row_o),
    .column_o    (column_o),
    .text_byte_o (text_byte_o),
    .last_o      (last_o)
  );

  always #2 clk_i = ~clk_i;

  src_byte_t   source_q[$];
  token_beat_t expected_beats[$];
  token_beat_t step_beats[$];
  int          mismatches = 0;
  int          live_phase = 0;
  int          hold_reqs = 0;

  // --------------------------------------------------------------------------
  // Lexer model state
  // --------------------------------------------------------------------------
  mode_e       lx_mode = M_START;
  int unsigned lx_row = 0;
  int unsigned lx_col = 0;
  int unsigned lx_start = 0;
  logic [7:0]  lx_indent = 8'd0;
  logic [1:0]  lx_pend = WS_NONE;
  logic [1:0]  lx_style = WS_NONE;
  logic [7:0]  lx_levels[STACK_DEPTH];
  int          lx_depth = 1;

  initial foreach (lx_levels[i]) lx_levels[i] = 8'd0;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic name_start(logic [7:0] c);
    return is_letter(c) || c == CH_UNDER;
  endfunction

  function automatic int unsigned bump(int unsigned v);
    return (v < POS_LIMIT) ? v + 1 : v;
  endfunction

  task automatic emit_beat(kind_e k, int unsigned r, int unsigned c, logic [7:0] b);
    token_beat_t t;
    if (step_beats.size() >= MAX_BEATS) return;   // overflow dropped
    t.kind = k;
    t.row  = (r > POS_LIMIT) ? 16'hFFFF : r[15:0];
    t.col  = (c > POS_LIMIT) ? 16'hFFFF : c[15:0];
    t.text = b;
    t.last = 1'b0;
    step_beats.insert(step_beats.size(), t);
  endtask

  task automatic put_token(kind_e k);
    emit_beat(k, lx_row, lx_start, 8'h00);
  endtask

  task automatic put_text(logic [7:0] c);
    emit_beat(K_TEXT, lx_row, lx_col, c);
  endtask

  task automatic enter_mode(mode_e m);
    lx_mode  = m;
    lx_start = lx_col;
  endtask

  task automatic start_indent(logic [1:0] w);
    enter_mode(M_INDENT);
    lx_indent = 8'd0;
    lx_pend   = w;
  endtask

  task automatic reseed();
    if (lx_depth == 0) begin
      lx_levels[0] = 8'd0;
      lx_depth = 1;
    end
  endtask

  task automatic open_token(logic [7:0] c);
    case (c)
      "+": enter_mode(M_PLUS);
      "-": enter_mode(M_MINUS);
      "*": enter_mode(M_STAR);
      "/": enter_mode(M_DIV);
      "@": enter_mode(M_MATMUL);
      "%": enter_mode(M_MOD);
      "&": enter_mode(M_BAND);
      "|": enter_mode(M_BOR);
      "^": enter_mode(M_XOR);
      "!": enter_mode(M_EXCL);
      "<": enter_mode(M_LESS);
      ">": enter_mode(M_GREATER);
      "=": enter_mode(M_ASSIGN);
      "~": enter_mode(M_INV);
      ".": enter_mode(M_DOT);
      ",": enter_mode(M_COMMA);
      "(": enter_mode(M_LPR);
      ")": enter_mode(M_RPR);
      "[": enter_mode(M_LSBR);
      "]": enter_mode(M_RSBR);
      "{": enter_mode(M_LBR);
      "}": enter_mode(M_RBR);
      ":": enter_mode(M_COLON);
      CH_QUOTE: enter_mode(M_STRING);
      CH_HASH: begin
        emit_beat(K_NEWLINE, lx_row, lx_col, 8'h00);
        enter_mode(M_COMMENT);
      end
      CH_NL: begin
        emit_beat(K_NEWLINE, lx_row, lx_col, 8'h00);
        enter_mode(M_NEWLINE);
      end
      CH_NUL:  put_token(K_EOF);
      default: enter_mode(M_SKIP);
    endcase
  endtask

  task automatic after_char(logic [7:0] c);
    if (name_start(c)) begin
      put_text(c);
      enter_mode(M_ID);
    end else if (is_numeral(c)) begin
      put_text(c);
      enter_mode(M_NUM1);
    end else begin
      open_token(c);
    end
  endtask

  task automatic indent_char(logic [7:0] c);
    logic [1:0] w;
    lx_col = bump(lx_col);
    if (c == CH_NL) begin
      lx_pend   = WS_NONE;
      lx_indent = 8'd0;
      lx_row    = bump(lx_row);
      lx_col    = 0;
      return;
    end
    if (c == CH_HASH) begin
      enter_mode(M_COMMENT);
      return;
    end
    if (lx_pend != WS_NONE) begin
      if (lx_style == WS_NONE) lx_style = lx_pend;
      // mixed indent: each later non-newline, non-hash byte gives a mix record
      if (lx_pend != lx_style) begin
        put_token(K_TABSPACEMIX);
        return;
      end
      if (lx_indent != 8'd255) lx_indent++;
      lx_pend = WS_NONE;
    end
    if (c == CH_SPACE || c == CH_TAB) begin
      w = (c == CH_SPACE) ? WS_SPACE : WS_TAB;
      if (lx_style == WS_NONE) lx_style = w;
      if (w == lx_style) begin
        if (lx_indent != 8'd255) lx_indent++;
      end else begin
        put_token(K_TABSPACEMIX);
      end
      return;
    end
    reseed();
    if (lx_indent > lx_levels[lx_depth-1]) begin
      // full stack: top entry is overwritten
      if (lx_depth < STACK_DEPTH) begin
        lx_levels[lx_depth] = lx_indent;
        lx_depth++;
      end else begin
        lx_levels[STACK_DEPTH-1] = lx_indent;
      end
      put_token(K_INDENT);
    end else if (lx_indent < lx_levels[lx_depth-1]) begin
      while (lx_depth > 0 && lx_levels[lx_depth-1] != lx_indent) begin
        lx_depth--;
        put_token(K_DEDENT);
      end
      if (lx_depth == 0) begin
        put_token(K_INDENTERROR);
        reseed();
      end
    end
    after_char(c);
  endtask

  task automatic operator_char(logic [7:0] c);
    kind_e      base;
    kind_e      eq_kind;
    logic       has_eq;
    logic [7:0] second;
    logic       second_is_mode;
    kind_e      second_kind;
    mode_e      second_mode;
    base = K_EOF; eq_kind = K_EOF; has_eq = 1'b1; second = CH_NUL;
    second_is_mode = 1'b0; second_kind = K_EOF; second_mode = M_START;
    lx_col = bump(lx_col);
    case (lx_mode)
      M_PLUS:    begin base = K_PLUS;       eq_kind = K_PLUSASS;   end
      M_MINUS:   begin
        base = K_MINUS; eq_kind = K_MINASS; second = ">"; second_kind = K_ARROW;
      end
      M_STAR:    begin base = K_STAR;       eq_kind = K_MULASS;    end
      M_DIV:     begin
        base = K_DIV; eq_kind = K_DIVASS; second = "/";
        second_is_mode = 1'b1; second_mode = M_IDIV;
      end
      M_MOD:     begin base = K_MOD;        eq_kind = K_MODASS;    end
      M_MATMUL:  begin base = K_MATMUL;     eq_kind = K_MATMULASS; end
      M_GREATER: begin
        base = K_GREATER; eq_kind = K_GREQUAL; second = ">";
        second_is_mode = 1'b1; second_mode = M_RSHIFT;
      end
      M_LESS:    begin
        base = K_LESS; eq_kind = K_LEQUAL; second = "<";
        second_is_mode = 1'b1; second_mode = M_LSHIFT;
      end
      M_ASSIGN:  begin base = K_ASSIGN;     eq_kind = K_EQUAL;     end
      M_BAND:    begin base = K_BAND;       eq_kind = K_BANDASS;   end
      M_BOR:     begin base = K_BOR;        eq_kind = K_BORASS;    end
      M_XOR:     begin base = K_XOR;        eq_kind = K_XORASS;    end
      M_EXCL:    begin base = K_UNEXPECTED; eq_kind = K_NOTEQ;     end
      M_IDIV:    begin base = K_IDIV;       eq_kind = K_IDIVASS;   end
      M_LSHIFT:  begin base = K_LSHIFT;     eq_kind = K_LSHIFTASS; end
      M_RSHIFT:  begin base = K_RSHIFT;     eq_kind = K_RSHIFTASS; end
      M_INV:     begin base = K_INV;   has_eq = 1'b0; end
      M_COLON:   begin base = K_COLON; has_eq = 1'b0; end
      M_DOT:     begin base = K_DOT;   has_eq = 1'b0; end
      M_COMMA:   begin base = K_COMMA; has_eq = 1'b0; end
      M_LPR:     begin base = K_LPR;   has_eq = 1'b0; end
      M_RPR:     begin base = K_RPR;   has_eq = 1'b0; end
      M_LSBR:    begin base = K_LSBR;  has_eq = 1'b0; end
      M_RSBR:    begin base = K_RSBR;  has_eq = 1'b0; end
      M_LBR:     begin base = K_LBR;   has_eq = 1'b0; end
      default:   begin base = K_RBR;   has_eq = 1'b0; end
    endcase
    if (has_eq && c == CH_EQ) begin
      put_token(eq_kind);
      enter_mode(M_SKIP);
    end else if (second != CH_NUL && c == second) begin
      if (second_is_mode) begin
        enter_mode(second_mode);
      end else begin
        put_token(second_kind);
        enter_mode(M_SKIP);
      end
    end else begin
      put_token(base);
      after_char(c);
    end
  endtask

  // Advance the model by one accepted byte and queue the beats it causes.
  task automatic lex_byte(logic [7:0] c);
    step_beats.delete();
    case (lx_mode)
      M_START: begin
        if (c == CH_HASH) enter_mode(M_COMMENT);
        else if (c == CH_SPACE || c == CH_TAB) start_indent(WS_NONE);
        else if (c != CH_NL) after_char(c);
      end
      M_SKIP: begin
        lx_col = bump(lx_col);
        after_char(c);
      end
      M_ID: begin
        lx_col = bump(lx_col);
        if (name_start(c) || is_numeral(c)) begin
          put_text(c);
        end else begin
          put_token(K_ID);
          open_token(c);
        end
      end
      M_STRING: begin
        lx_col = bump(lx_col);
        if (c == CH_QUOTE) begin
          put_token(K_STRING);
          enter_mode(M_SKIP);
        end else begin
          put_text(c);
        end
      end
      M_NUM1: begin
        lx_col = bump(lx_col);
        if (is_numeral(c)) begin
          put_text(c);
        end else if (c == CH_DOT) begin
          put_text(c);
          lx_mode = M_NUM2;
        end else begin
          put_token(K_NUMBER);
          if (name_start(c)) begin
            put_text(c);
            enter_mode(M_ID);
          end else begin
            open_token(c);
          end
        end
      end
      M_NUM2: begin
        lx_col = bump(lx_col);
        if (is_numeral(c)) begin
          put_text(c);
        end else begin
          put_token(K_NUMBER);
          open_token(c);
        end
      end
      M_COMMENT: begin
        if (c == CH_NL) begin
          lx_row = bump(lx_row);
          lx_col = 0;
          start_indent(WS_NONE);
        end
      end
      M_NEWLINE: begin
        lx_col = 1;
        lx_row = bump(lx_row);
        if (c == CH_HASH) begin
          enter_mode(M_COMMENT);
        end else if (c == CH_NUL) begin
          put_token(K_EOF);
        end else if (c == CH_SPACE || c == CH_TAB) begin
          start_indent((c == CH_SPACE) ? WS_SPACE : WS_TAB);
        end else if (c != CH_NL) begin
          // back at column zero: unwind the whole stack
          while (lx_depth > 0 && lx_levels[lx_depth-1] != 8'd0) begin
            lx_depth--;
            put_token(K_DEDENT);
          end
          reseed();
          after_char(c);
        end
      end
      M_INDENT: indent_char(c);
      default:  operator_char(c);
    endcase
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
    foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
  endtask

  // --------------------------------------------------------------------------
  // Source text generation
  // --------------------------------------------------------------------------
  int   fill_phase = 0;
  logic fill_drain = 1'b0;
  logic fill_hold = 1'b0;
  int   fill_levels[$];

  string op_words[] = '{"+", "+=", "-", "-=", "->", "*", "*=", "/", "/=", "//", "//=",
                        "%", "%=", "@", "@=", ">", ">=", ">>", ">>=", "<", "<=", "<<",
                        "<<=", "=", "==", "~", "&", "&=", "|", "|=", "^", "^=", "!=",
                        "!", ":", ".", ",", "(", ")", "[", "]", "{", "}"};

  task automatic add_byte(logic [7:0] c);
    src_byte_t s;
    s.code  = c;
    s.phase = fill_phase;
    s.drain = fill_drain;
    s.hold  = fill_hold;
    fill_drain = 1'b0;
    fill_hold  = 1'b0;
    source_q.insert(source_q.size(), s);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_spaces(int n);
    repeat (n) add_byte(CH_SPACE);
  endtask

  // One line of program-like text with a random indent and random tokens.
  task automatic add_line();
    int top;
    int pick;
    int depth;
    top = (fill_levels.size() == 0) ? 0 : fill_levels[$];
    case ($urandom_range(9))
      0, 1, 2, 3: depth = top;
      4, 5: begin
        depth = top + $urandom_range(1, 3);
        fill_levels.insert(fill_levels.size(), depth);
      end
      6, 7: begin
        if (fill_levels.size() == 0) depth = 0;
        else begin
          pick = $urandom_range(fill_levels.size() - 1);
          depth = fill_levels[pick];
          while (fill_levels.size() > pick + 1) void'(fill_levels.pop_back());
        end
      end
      8: depth = $urandom_range(6);           // may miss every level
      default: begin
        add_byte(CH_TAB);                     // tab against space style
        depth = $urandom_range(2);
      end
    endcase
    add_spaces(depth);
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(11))
        0, 1: begin
          add_byte($urandom_range(1) ? CH_UNDER : 8'("a" + $urandom_range(25)));
          repeat ($urandom_range(3)) begin
            case ($urandom_range(2))
              0: add_byte(8'("A" + $urandom_range(25)));
              1: add_byte(8'("a" + $urandom_range(25)));
              default: add_byte(8'("0" + $urandom_range(9)));
            endcase
          end
        end
        2: begin
          repeat ($urandom_range(1, 3)) add_byte(8'("0" + $urandom_range(9)));
          if ($urandom_range(1)) begin
            add_byte(CH_DOT);
            repeat ($urandom_range(2)) add_byte(8'("0" + $urandom_range(9)));
          end
        end
        3: begin
          add_byte(CH_QUOTE);
          repeat ($urandom_range(3)) add_byte($urandom_range(1) ? 8'("a" + $urandom_range(25))
                                                               : 8'($urandom_range(128, 255)));
          add_byte(CH_QUOTE);
        end
        4, 5, 6: add_text(op_words[$urandom_range(op_words.size() - 1)]);
        7, 8: add_byte(CH_SPACE);
        9: begin
          add_byte(CH_HASH);
          add_byte(8'($urandom_range(1, 255)));
        end
        10: add_byte(8'($urandom_range(128, 255)));
        default: add_byte(8'($urandom_range(1, 255)));
      endcase
    end
    if ($urandom_range(15) == 0) add_byte(CH_NUL);
    add_byte(CH_NL);
  endtask

  task automatic add_lines(int target);
    int stop_at;
    stop_at = source_q.size() + target;
    while (source_q.size() < stop_at) add_line();
  endtask

  // --------------------------------------------------------------------------
  // Driver: one source byte per beat, idling per the current phase profile
  // --------------------------------------------------------------------------
  function automatic int sender_idle(int p);
    return (p == 0) ? 38 : (p == 1) ? 86 : 0;
  endfunction

  function automatic int receiver_idle(int p);
    return (p == 0) ? 86 : (p == 1) ? 38 : 0;
  endfunction

  int unsigned drain_quiet = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      char_code_i <= 8'h00;
    end else begin
      if (in_valid_i && in_ready_o) lex_byte(char_code_i);
      if (!in_valid_i || in_ready_o) begin
        if (source_q.size() != 0 && source_q[0].drain) begin
          // sender pause until the block has gone quiet
          in_valid_i <= 1'b0;
          if (expected_beats.size() == 0) begin
            drain_quiet++;
            if (drain_quiet >= DRAIN_QUIET) source_q[0].drain = 1'b0;
          end else begin
            drain_quiet = 0;
          end
        end else if (source_q.size() != 0 &&
                     $urandom_range(99) >= sender_idle(source_q[0].phase)) begin
          in_valid_i  <= 1'b1;
          char_code_i <= source_q[0].code;
          live_phase  <= source_q[0].phase;
          if (source_q[0].hold) hold_reqs++;
          drain_quiet = 0;
          void'(source_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure, with one long hold-off to fill the block
  // --------------------------------------------------------------------------
  int          hold_seen = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_idle(live_phase));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every result beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    token_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected beat: kind %0d row %0d col %0d byte %02h last %0b",
                   $realtime, kind_o, row_o, column_o, text_byte_o, last_o);
      end else begin
        want = expected_beats.pop_front();
        if (kind_o !== want.kind || row_o !== want.row || column_o !== want.col ||
            text_byte_o !== want.text || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] beat mismatch: exp kind %0d row %0d col %0d byte %02h last %0b",
                     $realtime, want.kind, want.row, want.col, want.text, want.last);
            $display("[%0t]                got kind %0d row %0d col %0d byte %02h last %0b",
                     $realtime, kind_o, row_o, column_o, text_byte_o, last_o);
          end
        end
      end
    end
  end

  // Watchdog
  int unsigned cycles = 0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("indent_aware_tokenizer verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Source text and run control
  // --------------------------------------------------------------------------
  initial begin
    // Directed: names, numbers, a string, high bytes, a comment, an indent,
    // tab/space mix, a dedent ending in indent error, end of input.
    fill_phase = 0;
    add_text("_aZ9 0.5 1x \"s\" ");
    add_byte(8'h80);
    add_byte(8'hFF);
    add_text("#c\n  b\n\tc\n d\n");
    add_byte(CH_NUL);
    add_byte(CH_NL);
    add_lines(110);

    // Sender slow, receiver fast; long hold-off early in the phase.
    fill_phase = 1;
    fill_drain = 1'b1;
    add_text("z\n");
    fill_levels.delete();
    fill_hold = 1'b1;
    add_lines(110);

    // No idling; then a ladder deeper than the stack and a full unwind.
    fill_phase = 2;
    fill_drain = 1'b1;
    add_text("z\n");
    fill_levels.delete();
    add_lines(20);
    add_text("z\n");
    for (int k = 1; k <= STACK_DEPTH + 1; k++) begin
      add_spaces(k);
      add_text("a\n");
    end
    add_text("q\n");
    add_byte(CH_NUL);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (source_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("indent_aware_tokenizer verification clean");
    end else begin
      $display("indent_aware_tokenizer verification failed");
    end
    $finish;
  end

endmodule
